FILE: rtl/bdq_pkg.sv
// Shared constants and types for the bounded double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 4;
  localparam int RCNT_W       = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_DELETE     = 4'd4,
    CMD_READ_ALL   = 4'd5,
    CMD_READ_FIRST = 4'd6,
    CMD_READ_LAST  = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_MARK
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/bdq_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram
  import bdq_pkg::*;
#(
  parameter int DEPTH  = CAPACITY_DEF,
  parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/bounded_deque_with_value_delete.sv
// Top level: bounded double-ended queue with delete-by-value and read-out.
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to CAPACITY signed words in a circular buffer held in a
// single-port-read RAM. Push, pop and clear complete in the cycle the
// transaction is taken; the next command is taken in the following cycle.
// Delete-by-value walks the stored entries through the one RAM read port,
// one entry per cycle. A read-out fetches each entry in two steps (address,
// then data into the output register), and out_stall can hold the output;
// an empty read-out gives one marker result, which out_stall can also hold.
// in_stall is high while a delete or read-out runs. Entries are undefined
// until written; no clearing pass.
module bounded_deque_with_value_delete
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_operand_value,
  input  wire logic [RCNT_W-1:0]        in_read_count,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_element_value,
  output logic                          out_element_valid,
  output logic                          out_last_of_run
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(f) + (CNT_W+1)'(p);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic [CNT_W-1:0]   wr_r, wr_nxt;
  logic               pend_r, pend_nxt;
  logic [DATA_W-1:0]  del_val_r, del_val_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic               out_elem_valid_r, out_elem_valid_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_load;
  logic               out_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic               k_big;
  logic [CNT_W-1:0]   rd_start;
  logic [CNT_W-1:0]   rd_count;
  logic [IDX_W-1:0]   push_front_slot;

  bdq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free        = !out_valid_r || !out_stall;
  assign k_big           = CMP_W'(in_read_count) >= CMP_W'(occ_r);
  assign push_front_slot = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - IDX_W'(1);

  always_comb begin
    rd_start = '0;
    rd_count = occ_r;
    unique case (cmd_t'(in_command))
      CMD_READ_FIRST: begin
        if (!k_big) begin
          rd_count = CNT_W'(in_read_count);
        end
      end
      CMD_READ_LAST: begin
        if (!k_big) begin
          rd_count = CNT_W'(in_read_count);
          rd_start = occ_r - CNT_W'(in_read_count);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt          = state_r;
    occ_nxt            = occ_r;
    front_nxt          = front_r;
    pos_nxt            = pos_r;
    end_nxt            = end_r;
    wr_nxt             = wr_r;
    pend_nxt           = pend_r;
    del_val_nxt        = del_val_r;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_wdata          = in_operand_value;
    ram_re             = 1'b0;
    ram_raddr          = '0;
    out_load           = 1'b0;
    out_value_nxt      = ram_rdata;
    out_elem_valid_nxt = 1'b1;
    out_last_nxt       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_command))
            CMD_PUSH_FRONT: begin
              if (occ_r < CNT_W'(CAPACITY)) begin
                front_nxt = push_front_slot;
                ram_we    = 1'b1;
                ram_waddr = push_front_slot;
                occ_nxt   = occ_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (occ_r < CNT_W'(CAPACITY)) begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_r, occ_r);
                occ_nxt   = occ_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (occ_r != '0) begin
                occ_nxt   = occ_r - CNT_W'(1);
                front_nxt = (occ_r == CNT_W'(1)) ? '0 : slot_of(front_r, CNT_W'(1));
              end
            end
            CMD_POP_BACK: begin
              if (occ_r != '0) begin
                occ_nxt = occ_r - CNT_W'(1);
                if (occ_r == CNT_W'(1)) begin
                  front_nxt = '0;
                end
              end
            end
            CMD_DELETE: begin
              del_val_nxt = in_operand_value;
              pos_nxt     = '0;
              wr_nxt      = '0;
              pend_nxt    = 1'b0;
              state_nxt   = ST_DEL;
            end
            CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
              pos_nxt   = rd_start;
              end_nxt   = rd_start + rd_count;
              state_nxt = (rd_count == '0) ? ST_MARK : ST_RD_ADDR;
            end
            CMD_CLEAR: begin
              occ_nxt   = '0;
              front_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DEL: begin
        if (pend_r && (ram_rdata != del_val_r)) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(front_r, wr_r);
          ram_wdata = ram_rdata;
          wr_nxt    = wr_r + CNT_W'(1);
        end
        if (pos_r < occ_r) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(front_r, pos_r);
          pos_nxt   = pos_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if ((pos_r == occ_r) && !pend_r) begin
          occ_nxt   = wr_r;
          if (wr_r == '0) begin
            front_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        ram_re    = 1'b1;
        ram_raddr = slot_of(front_r, pos_r);
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = (pos_r + CNT_W'(1)) == end_r;
          pos_nxt      = pos_r + CNT_W'(1);
          state_nxt    = out_last_nxt ? ST_IDLE : ST_RD_ADDR;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_value_nxt      = '0;
          out_elem_valid_nxt = 1'b0;
          out_last_nxt       = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      front_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      front_r     <= front_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    end_r     <= end_nxt;
    wr_r      <= wr_nxt;
    del_val_r <= del_val_nxt;
    if (out_load) begin
      out_value_r      <= out_value_nxt;
      out_elem_valid_r <= out_elem_valid_nxt;
      out_last_r       <= out_last_nxt;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_element_value = out_value_r;
  assign out_element_valid = out_elem_valid_r;
  assign out_last_of_run   = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < IDX_W'(CAPACITY) || (CAPACITY == (1 << IDX_W)))
    else $error("front index out of range");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> front_r == '0)
    else $error("empty store with nonzero front index");

  a_del_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DEL |-> wr_r <= pos_r)
    else $error("delete write pointer passed read pointer");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(out_value_r) && $stable(out_last_r))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: bench/bdq_checker.sv
// Checker for the bounded deque: tracks the contents, predicts read-outs, compares results.
`timescale 1ns / 1ps

module bdq_checker
  import bdq_pkg::*;
#(
  parameter int CAP = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_operand_value,
  input  logic [RCNT_W-1:0]        in_read_count,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_element_value,
  input  logic                     out_element_valid,
  input  logic                     out_last_of_run,
  output int                       fail_count,
  output int                       pending,
  output int                       cmd_total,
  output int                       elem_total,
  output int                       peak_fill
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     valid;
    logic                     last;
  } elem_t;

  logic signed [DATA_W-1:0] slots [CAP];
  int                       head;
  int                       fill;
  elem_t                    expected_elems [$];
  elem_t                    oldest;

  task automatic report(input string msg);
    $display("mismatch: %s at %0t", msg, $realtime);
    fail_count++;
  endtask

  function automatic int slot_at(input int pos);
    return (head + pos) % CAP;
  endfunction

  task automatic emit_range(input int start, input int n);
    elem_t e;
    int    i;
    if (n == 0) begin
      e.value = '0;
      e.valid = 1'b0;
      e.last  = 1'b1;
      expected_elems.push_back(e);
    end else begin
      for (i = 0; i < n; i++) begin
        e.value = slots[slot_at(start + i)];
        e.valid = 1'b1;
        e.last  = (i == n - 1);
        expected_elems.push_back(e);
      end
    end
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] v, input int k);
    logic signed [DATA_W-1:0] kept [CAP];
    int                       i;
    int                       n;
    n = 0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (fill < CAP) begin
          head = (head + CAP - 1) % CAP;
          slots[head] = v;
          fill++;
        end
      end
      CMD_PUSH_BACK: begin
        if (fill < CAP) begin
          slots[slot_at(fill)] = v;
          fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (fill > 0) begin
          head = (head + 1) % CAP;
          fill--;
          if (fill == 0) head = 0;
        end
      end
      CMD_POP_BACK: begin
        if (fill > 0) begin
          fill--;
          if (fill == 0) head = 0;
        end
      end
      CMD_DELETE: begin
        for (i = 0; i < fill; i++) begin
          if (slots[slot_at(i)] !== v) begin
            kept[n] = slots[slot_at(i)];
            n++;
          end
        end
        for (i = 0; i < n; i++) slots[slot_at(i)] = kept[i];
        fill = n;
        if (fill == 0) head = 0;
      end
      CMD_READ_ALL:   emit_range(0, fill);
      CMD_READ_FIRST: emit_range(0, (k >= fill) ? fill : k);
      CMD_READ_LAST: begin
        if (k >= fill) emit_range(0, fill);
        else emit_range(fill - k, k);
      end
      CMD_CLEAR: begin
        fill = 0;
        head = 0;
      end
      default: ;
    endcase
    if (fill > peak_fill) peak_fill = fill;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head = 0;
      fill = 0;
      expected_elems.delete();
    end else begin
      if (out_valid && !out_stall) begin
        elem_total++;
        if (expected_elems.size() == 0) begin
          report($sformatf("unexpected result value %0d valid %0b last %0b",
                           out_element_value, out_element_valid, out_last_of_run));
        end else begin
          oldest = expected_elems.pop_front();
          if (out_element_value !== oldest.value)
            report($sformatf("element_value %0d, expected %0d",
                             out_element_value, oldest.value));
          if (out_element_valid !== oldest.valid)
            report($sformatf("element_valid %0b, expected %0b",
                             out_element_valid, oldest.valid));
          if (out_last_of_run !== oldest.last)
            report($sformatf("last_of_run %0b, expected %0b",
                             out_last_of_run, oldest.last));
        end
      end
      if (in_valid && !in_stall) begin
        cmd_total++;
        apply_command(in_command, in_operand_value, int'(in_read_count));
      end
    end
    pending = expected_elems.size();
  end

endmodule

FILE: bench/bounded_deque_with_value_delete_test.sv
// Testbench top for the bounded deque: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete_test
  import bdq_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 4'd15;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command       = '0;
  logic signed [DATA_W-1:0] in_operand_value = '0;
  logic [RCNT_W-1:0]        in_read_count    = '0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  logic signed [DATA_W-1:0] out_element_value;
  logic                     out_element_valid;
  logic                     out_last_of_run;

  int fail_count;
  int pending;
  int cmd_total;
  int elem_total;
  int peak_fill;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int sent         = 0;
  int drain_cycles;

  cmd_t push_ops [2] = '{CMD_PUSH_FRONT, CMD_PUSH_BACK};
  cmd_t pop_ops  [2] = '{CMD_POP_FRONT, CMD_POP_BACK};
  cmd_t read_ops [3] = '{CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST};

  always #5 clk = ~clk;

  bounded_deque_with_value_delete #(
    .CAPACITY(CAPACITY_DEF)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_operand_value (in_operand_value),
    .in_read_count    (in_read_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_value(out_element_value),
    .out_element_valid(out_element_valid),
    .out_last_of_run  (out_last_of_run)
  );

  bdq_checker #(
    .CAP(CAPACITY_DEF)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_operand_value (in_operand_value),
    .in_read_count    (in_read_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_value(out_element_value),
    .out_element_valid(out_element_valid),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending          (pending),
    .cmd_total        (cmd_total),
    .elem_total       (elem_total),
    .peak_fill        (peak_fill)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    if ($urandom_range(99) < 60) return 32'($urandom_range(3)) - 32'd1;
    return $urandom();
  endfunction

  function automatic logic [RCNT_W-1:0] rand_count();
    if ($urandom_range(1) == 0) return RCNT_W'($urandom_range(8));
    return RCNT_W'($urandom_range(63));
  endfunction

  task automatic send(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] v,
                      input logic [RCNT_W-1:0] k);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_operand_value <= v;
    in_read_count    <= k;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd <= CMD_CLEAR) sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic run_random(input int target);
    int pick;
    int n;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        n = $urandom_range(1, 8);
        repeat (n) send(push_ops[$urandom_range(1)], rand_word(), rand_count());
      end else if (pick < 45) begin
        n = $urandom_range(1, 4);
        repeat (n) send(pop_ops[$urandom_range(1)], rand_word(), rand_count());
      end else if (pick < 60) begin
        send(CMD_DELETE, rand_word(), rand_count());
      end else if (pick < 90) begin
        send(read_ops[$urandom_range(2)], rand_word(), rand_count());
      end else if (pick < 92) begin
        repeat (CAPACITY_DEF + 2) send(push_ops[$urandom_range(1)], rand_word(), rand_count());
        send(CMD_READ_ALL, rand_word(), rand_count());
      end else if (pick < 96) begin
        send(CMD_CLEAR, rand_word(), rand_count());
      end else begin
        send(CMD_UNDEF_LO + CMD_W'($urandom_range(CMD_UNDEF_HI - CMD_UNDEF_LO)),
             rand_word(), rand_count());
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_idle_pct  = 6;
    out_idle_pct = 82;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(CMD_READ_ALL,   '0, '0);
    send(CMD_POP_FRONT,  '0, '0);
    send(CMD_POP_BACK,   '0, '0);
    send(CMD_READ_FIRST, '0, 6'd5);
    send(CMD_PUSH_BACK,  32'sh7fffffff, '0);
    send(CMD_PUSH_FRONT, 32'sh80000000, '0);
    send(CMD_PUSH_BACK,  32'sd0, '0);
    send(CMD_PUSH_BACK,  -32'sd1, '0);
    send(CMD_READ_FIRST, '0, 6'd0);
    send(CMD_READ_FIRST, '0, 6'd2);
    send(CMD_READ_LAST,  '0, 6'd1);
    send(CMD_READ_LAST,  '0, 6'd63);
    send(CMD_DELETE,     -32'sd1, '0);
    send(CMD_DELETE,     32'sd12345, '0);
    send(CMD_READ_ALL,   '0, '0);
    send(CMD_POP_FRONT,  '0, '0);
    send(CMD_POP_BACK,   '0, '0);
    send(CMD_POP_BACK,   '0, '0);
    send(CMD_PUSH_FRONT, 32'sd5, '0);
    send(CMD_DELETE,     32'sd5, '0);
    send(CMD_READ_LAST,  '0, 6'd3);
    send(CMD_PUSH_BACK,  32'sd9, '0);
    send(CMD_CLEAR,      '0, '0);
    send(CMD_READ_ALL,   '0, '0);
    send(CMD_UNDEF_HI,   -32'sd1, 6'd63);
    hold_until_drained();

    run_random(90);
    hold_until_drained();
    in_idle_pct  = 82;
    out_idle_pct = 6;
    run_random(180);
    hold_until_drained();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(270);
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 200_000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (100) @(negedge clk);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("summary: %0d commands across three idling mixes, %0d results checked",
             cmd_total, elem_total);
    $display("summary: peak fill %0d of %0d entries", peak_fill, CAPACITY_DEF);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
